/* rtl/rsm_pkg.sv */
package rsm_pkg;

  localparam int unsigned SECTOR_W = 37;
  localparam int unsigned CHUNK_W  = 16;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned DISK_W   = 4;
  localparam int unsigned ROW_IN_W = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned MAX_DISKS_DEF = 16;
  localparam int unsigned ROW_BITS_DEF  = 32;

  localparam logic [MODE_W-1:0] MODE_RAID0  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RAID01 = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RAID10 = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RAID4  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RAID5  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_RAID_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISK_COUNT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_SECTORS = 2'd2;

endpackage

/* rtl/raid_sector_mapper.sv */
// raid_sector_mapper: maps a (row, disk) request to the logical sector held
// there for the configured RAID layout, or flags it as parity or a bad disk.
// Channels: in_valid/in_stall carry in_row and in_disk; out_valid/out_stall
// carry out_sector, out_is_parity and out_bad_disk, one result per request.
// Configuration: cfg_we with cfg_index and cfg_wdata writes raid_mode (0),
// disk_count (1) or chunk_sectors (2); other indexes are ignored. Write only
// while no request is in flight.
// Structure: a row of ROW_BITS cells forms row mod chunk and row mod disk
// count one row bit per cell, then one mapping stage multiplies and
// registers the result.
// Throughput: one request per cycle while the receiver does not stall; each stage holds one request.
// Reset empties every stage and loads raid0, two disks, one sector per chunk.
// When the receiver stalls, the result holds and the stages fill up behind it;
// in_stall rises only once the cell right behind the input is occupied and
// cannot advance.
module raid_sector_mapper import rsm_pkg::*; #(
  parameter int unsigned MAX_DISKS = MAX_DISKS_DEF,
  parameter int unsigned ROW_BITS  = ROW_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CHUNK_W-1:0]   cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ROW_IN_W-1:0]  in_row,
  input  logic [DISK_W-1:0]    in_disk,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [SECTOR_W-1:0]  out_sector,
  output logic                 out_is_parity,
  output logic                 out_bad_disk
);

  localparam int unsigned NW = $clog2(MAX_DISKS + 1);
  localparam int unsigned CW = (NW > COUNT_W) ? NW : COUNT_W;

  logic [MODE_W-1:0]  mode_r;
  logic [COUNT_W-1:0] count_r;
  logic [CHUNK_W-1:0] chunk_r;
  logic [CW-1:0]      cnt_w;
  logic [CW-1:0]      cnt_eff;
  logic [NW-1:0]      n_disks;
  logic [CHUNK_W-1:0] chunk_eff;

  logic                v     [ROW_BITS+1];
  logic                rdy   [ROW_BITS+1];
  logic [ROW_BITS-1:0] row   [ROW_BITS+1];
  logic [DISK_W-1:0]   disk  [ROW_BITS+1];
  logic [CHUNK_W-1:0]  rc    [ROW_BITS+1];
  logic [NW-1:0]       rn    [ROW_BITS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_RAID0;
      count_r <= COUNT_W'(2);
      chunk_r <= CHUNK_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RAID_MODE:     mode_r  <= cfg_wdata[MODE_W-1:0];
        REG_DISK_COUNT:    count_r <= cfg_wdata[COUNT_W-1:0];
        REG_CHUNK_SECTORS: chunk_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cnt_w   = CW'(count_r);
    cnt_eff = cnt_w;
    if (cnt_w < CW'(2)) begin
      cnt_eff = CW'(2);
    end
    if (cnt_w > CW'(MAX_DISKS)) begin
      cnt_eff = CW'(MAX_DISKS);
    end
    n_disks   = cnt_eff[NW-1:0];
    chunk_eff = (chunk_r == '0) ? CHUNK_W'(1) : chunk_r;
  end

  assign v[0]    = in_valid;
  assign row[0]  = ROW_BITS'(in_row);
  assign disk[0] = in_disk;
  assign rc[0]   = '0;
  assign rn[0]   = '0;
  assign in_stall = !rdy[0];

  for (genvar i = 0; i < ROW_BITS; i++) begin : g_cell
    rsm_cell #(
      .ROW_BITS (ROW_BITS),
      .NW       (NW),
      .BIT      (ROW_BITS - 1 - i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .chunk    (chunk_eff),
      .n_disks  (n_disks),
      .up_valid (v[i]),
      .up_ready (rdy[i]),
      .up_row   (row[i]),
      .up_disk  (disk[i]),
      .up_rc    (rc[i]),
      .up_rn    (rn[i]),
      .dn_valid (v[i+1]),
      .dn_ready (rdy[i+1]),
      .dn_row   (row[i+1]),
      .dn_disk  (disk[i+1]),
      .dn_rc    (rc[i+1]),
      .dn_rn    (rn[i+1])
    );
  end

  rsm_map #(
    .ROW_BITS (ROW_BITS),
    .NW       (NW)
  ) u_map (
    .clk           (clk),
    .rst_n         (rst_n),
    .mode          (mode_r),
    .chunk         (chunk_eff),
    .n_disks       (n_disks),
    .up_valid      (v[ROW_BITS]),
    .up_ready      (rdy[ROW_BITS]),
    .up_row        (row[ROW_BITS]),
    .up_disk       (disk[ROW_BITS]),
    .up_rc         (rc[ROW_BITS]),
    .up_rn         (rn[ROW_BITS]),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sector    (out_sector),
    .out_is_parity (out_is_parity),
    .out_bad_disk  (out_bad_disk)
  );

  a_par_bad_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_parity && out_bad_disk))
    else $error("parity and bad disk both set");

  a_par_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_is_parity || out_bad_disk)) |-> (out_sector == '0))
    else $error("nonzero sector on parity or bad disk");

  a_par_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && mode_r != MODE_RAID4 && mode_r != MODE_RAID5) |-> !out_is_parity)
    else $error("parity in a layout without parity");

  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !v[1] |-> !in_stall)
    else $error("input stalled with first cell empty");

endmodule

/* rtl/rsm_cell.sv */
module rsm_cell import rsm_pkg::*; #(
  parameter int unsigned ROW_BITS = ROW_BITS_DEF,
  parameter int unsigned NW       = 5,
  parameter int unsigned BIT      = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [CHUNK_W-1:0]  chunk,
  input  logic [NW-1:0]       n_disks,
  input  logic                up_valid,
  output logic                up_ready,
  input  logic [ROW_BITS-1:0] up_row,
  input  logic [DISK_W-1:0]   up_disk,
  input  logic [CHUNK_W-1:0]  up_rc,
  input  logic [NW-1:0]       up_rn,
  output logic                dn_valid,
  input  logic                dn_ready,
  output logic [ROW_BITS-1:0] dn_row,
  output logic [DISK_W-1:0]   dn_disk,
  output logic [CHUNK_W-1:0]  dn_rc,
  output logic [NW-1:0]       dn_rn
);

  logic                v_r;
  logic [ROW_BITS-1:0] row_r;
  logic [DISK_W-1:0]   disk_r;
  logic [CHUNK_W-1:0]  rc_r;
  logic [NW-1:0]       rn_r;
  logic [CHUNK_W:0]    tc;
  logic [NW:0]         tn;
  logic [CHUNK_W-1:0]  rc_nxt;
  logic [NW-1:0]       rn_nxt;

  assign up_ready = !v_r || dn_ready;

  always_comb begin
    tc = {up_rc, up_row[BIT]};
    tn = {up_rn, up_row[BIT]};
    if (tc >= {1'b0, chunk}) begin
      tc = tc - {1'b0, chunk};
    end
    if (tn >= {1'b0, n_disks}) begin
      tn = tn - {1'b0, n_disks};
    end
    rc_nxt = tc[CHUNK_W-1:0];
    rn_nxt = tn[NW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      row_r  <= up_row;
      disk_r <= up_disk;
      rc_r   <= rc_nxt;
      rn_r   <= rn_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_row   = row_r;
  assign dn_disk  = disk_r;
  assign dn_rc    = rc_r;
  assign dn_rn    = rn_r;

endmodule

/* rtl/rsm_map.sv */
module rsm_map import rsm_pkg::*; #(
  parameter int unsigned ROW_BITS = ROW_BITS_DEF,
  parameter int unsigned NW       = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [MODE_W-1:0]   mode,
  input  logic [CHUNK_W-1:0]  chunk,
  input  logic [NW-1:0]       n_disks,
  input  logic                up_valid,
  output logic                up_ready,
  input  logic [ROW_BITS-1:0] up_row,
  input  logic [DISK_W-1:0]   up_disk,
  input  logic [CHUNK_W-1:0]  up_rc,
  input  logic [NW-1:0]       up_rn,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SECTOR_W-1:0] out_sector,
  output logic                out_is_parity,
  output logic                out_bad_disk
);

  localparam int unsigned DC_W = DISK_W + CHUNK_W;

  logic                v_r;
  logic [SECTOR_W-1:0] sector_r;
  logic                par_r;
  logic                bad_r;
  logic [SECTOR_W-1:0] sector_nxt;
  logic                par_nxt;
  logic                bad_nxt;
  logic [NW:0]         dsk;
  logic [NW:0]         half;
  logic [NW:0]         d1;
  logic [NW:0]         d2;
  logic [NW:0]         s5;
  logic [ROW_BITS-1:0] mul_a;
  logic [NW:0]         mul_b;
  logic [SECTOR_W-1:0] add_c;
  logic                use_mul;

  assign up_ready = !v_r || !out_stall;

  always_comb begin
    dsk  = (NW+1)'(up_disk);
    half = {1'b0, n_disks} >> 1;
    d1   = (dsk >= half) ? dsk - half : dsk;
    d2   = (d1 >= half) ? d1 - half : d1;
    s5   = dsk + (NW+1)'(up_rn);
    if (s5 >= {1'b0, n_disks}) begin
      s5 = s5 - {1'b0, n_disks};
    end
    bad_nxt = dsk >= {1'b0, n_disks};
    par_nxt = 1'b0;
    use_mul = 1'b1;
    mul_a   = up_row;
    mul_b   = {1'b0, n_disks} - 1'b1;
    add_c   = '0;
    case (mode)
      MODE_RAID0: begin
        mul_a = up_row - ROW_BITS'(up_rc);
        mul_b = {1'b0, n_disks};
        add_c = SECTOR_W'(DC_W'(up_disk) * DC_W'(chunk)) + SECTOR_W'(up_rc);
      end
      MODE_RAID01: begin
        mul_b = half;
        add_c = SECTOR_W'(d2);
      end
      MODE_RAID10: begin
        mul_b = half;
        add_c = SECTOR_W'(up_disk >> 1);
      end
      MODE_RAID4: begin
        add_c = SECTOR_W'(up_disk);
        if (dsk == {1'b0, n_disks} - 1'b1) begin
          par_nxt = 1'b1;
        end
      end
      MODE_RAID5: begin
        add_c = SECTOR_W'(s5);
        if (dsk == {1'b0, n_disks} - 1'b1 - (NW+1)'(up_rn)) begin
          par_nxt = 1'b1;
        end
      end
      default: begin
        use_mul = 1'b0;
      end
    endcase
    sector_nxt = SECTOR_W'(SECTOR_W'(mul_a) * SECTOR_W'(mul_b)) + add_c;
    if (bad_nxt || par_nxt || !use_mul) begin
      sector_nxt = '0;
    end
    if (bad_nxt) begin
      par_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      sector_r <= sector_nxt;
      par_r    <= par_nxt;
      bad_r    <= bad_nxt;
    end
  end

  assign out_valid     = v_r;
  assign out_sector    = sector_r;
  assign out_is_parity = par_r;
  assign out_bad_disk  = bad_r;

endmodule

/* tb/raid_sector_mapper_tb.sv */
module raid_sector_mapper_tb;
  import rsm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [MODE_W-1:0]    MODE_UNDEF_LO = 3'd5;
  localparam logic [MODE_W-1:0]    MODE_UNDEF_HI = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_NONE      = 2'd3;

  typedef struct packed {
    logic [SECTOR_W-1:0] sector;
    logic                is_parity;
    logic                bad_disk;
  } map_result_t;

  class sector_scoreboard;
    logic [MODE_W-1:0]  mode;
    logic [COUNT_W-1:0] count;
    logic [CHUNK_W-1:0] chunk;
    map_result_t        pending[$];
    int                 errors;
    int                 checked;

    function void reset_regs();
      mode = MODE_RAID0;
      count = COUNT_W'(2);
      chunk = CHUNK_W'(1);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CHUNK_W-1:0] val);
      if (idx == REG_RAID_MODE) mode = val[MODE_W-1:0];
      else if (idx == REG_DISK_COUNT) count = val[COUNT_W-1:0];
      else if (idx == REG_CHUNK_SECTORS) chunk = val;
    endfunction

    function map_result_t map_position(logic [ROW_IN_W-1:0] row, logic [DISK_W-1:0] disk);
      map_result_t r;
      longint unsigned n, half, c, off, ppos, idx, s, rw, dk;
      r = '0;
      s = 0;
      rw = row;
      dk = disk;
      n = count;
      if (n < 2) n = 2;
      if (n > MAX_DISKS_DEF) n = MAX_DISKS_DEF;
      half = n / 2;
      if (dk >= n) begin
        r.bad_disk = 1'b1;
      end else if (mode == MODE_RAID0) begin
        c = (chunk == 0) ? 1 : chunk;
        off = rw % c;
        s = (rw - off) * n + dk * c + off;
      end else if (mode == MODE_RAID01) begin
        s = rw * half + (dk % half);
      end else if (mode == MODE_RAID10) begin
        s = rw * half + dk / 2;
      end else if (mode == MODE_RAID4) begin
        if (dk == n - 1) r.is_parity = 1'b1;
        else s = rw * (n - 1) + dk;
      end else if (mode == MODE_RAID5) begin
        ppos = (n - 1) - (rw % n);
        if (dk == ppos) begin
          r.is_parity = 1'b1;
        end else begin
          idx = (dk + n - ppos - 1) % n;
          s = rw * (n - 1) + idx;
        end
      end
      r.sector = s[SECTOR_W-1:0];
      return r;
    endfunction

    function void note_request(logic [ROW_IN_W-1:0] row, logic [DISK_W-1:0] disk);
      pending.push_back(map_position(row, disk));
    endfunction

    function void check_result(map_result_t got);
      map_result_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result sector=%0h", $time, got.sector);
        errors++;
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (got.sector !== exp.sector) begin
        $display("%0t: sector exp %0h got %0h", $time, exp.sector, got.sector);
        errors++;
      end
      if (got.is_parity !== exp.is_parity) begin
        $display("%0t: is_parity exp %0b got %0b", $time, exp.is_parity, got.is_parity);
        errors++;
      end
      if (got.bad_disk !== exp.bad_disk) begin
        $display("%0t: bad_disk exp %0b got %0b", $time, exp.bad_disk, got.bad_disk);
        errors++;
      end
    endfunction
  endclass

  logic                 clk, rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CHUNK_W-1:0]   cfg_wdata;
  logic                 in_valid, in_stall;
  logic [ROW_IN_W-1:0]  in_row;
  logic [DISK_W-1:0]    in_disk;
  logic                 out_valid, out_stall;
  logic [SECTOR_W-1:0]  out_sector;
  logic                 out_is_parity, out_bad_disk;

  sector_scoreboard sb;
  int  cycles = 0;
  bit  calm;
  localparam int CYCLE_LIMIT = 200000;

  raid_sector_mapper dut (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("raid_sector_mapper_tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_request(in_row, in_disk);
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{out_sector, out_is_parity, out_bad_disk});
  end

  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= !calm && ($urandom_range(99) < 32);
  end

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CHUNK_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic send_request(logic [ROW_IN_W-1:0] row, logic [DISK_W-1:0] disk);
    while (!calm && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_row <= row;
    in_disk <= disk;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic logic [ROW_IN_W-1:0] pick_row();
    case ($urandom_range(3))
      0: return $urandom_range(64);
      1: return ~$urandom_range(64);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [MODE_W-1:0]  modes[6];
    logic [COUNT_W-1:0] counts[7];
    logic [CHUNK_W-1:0] chunks[6];
    int k;
    sb = new();
    sb.reset_regs();
    modes = '{MODE_RAID0, MODE_RAID01, MODE_RAID10, MODE_RAID4, MODE_RAID5, MODE_UNDEF_HI};
    counts = '{5'd0, 5'd2, 5'd3, 5'd7, 5'd16, 5'd31, 5'd8};
    chunks = '{16'd0, 16'd1, 16'd3, 16'd64, 16'hFFFF, 16'd7};
    calm = 0;
    rst_n = 0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 0;
    in_row = '0;
    in_disk = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_request('0, 4'd0);
    send_request('1, 4'd1);
    send_request('1, 4'd15);
    drain();
    write_cfg(REG_DISK_COUNT, 16'd16);
    write_cfg(REG_CHUNK_SECTORS, 16'hFFFF);
    send_request('1, 4'd15);
    send_request(32'h0001_0000, 4'd0);
    for (k = 0; k < 5; k++) begin
      drain();
      write_cfg(REG_RAID_MODE, CHUNK_W'(modes[k]));
      write_cfg(REG_DISK_COUNT, (k % 2) ? 16'd3 : 16'd16);
      send_request('1, 4'd15);
      send_request('0, 4'd2);
      send_request(32'd5, 4'd1);
      send_request(32'hFFFF_FFFE, 4'd0);
    end
    drain();
    write_cfg(REG_RAID_MODE, CHUNK_W'(MODE_UNDEF_LO));
    send_request(32'd9, 4'd1);
    send_request(32'd9, 4'd9);
    drain();
    write_cfg(REG_NONE, 16'hFFFF);

    for (k = 0; k < 800; k++) begin
      if (k % 50 == 0) begin
        drain();
        write_cfg(REG_RAID_MODE,
                  CHUNK_W'($urandom_range(5) == 5 ? modes[5] : modes[$urandom_range(4)]));
        write_cfg(REG_DISK_COUNT, CHUNK_W'(counts[$urandom_range(6)]));
        write_cfg(REG_CHUNK_SECTORS,
                  $urandom_range(1) ? chunks[$urandom_range(5)] : CHUNK_W'($urandom));
        if ($urandom_range(3) == 0) write_cfg(REG_NONE, CHUNK_W'($urandom));
      end
      calm = (k >= 300 && k < 400);
      send_request(pick_row(), DISK_W'($urandom_range(15)));
    end
    drain();
    $display("Covered raid0/01/10/4/5 and unknown layouts, disk counts 0..31, chunks 0..65535;");
    $display("%0d results checked under random stalls on both sides.", sb.checked);
    if (sb.errors == 0) $display("raid_sector_mapper_tb: PASS");
    else $display("raid_sector_mapper_tb: FAIL");
    $finish;
  end
endmodule

/* raid_sector_mapper.f */
rtl/rsm_pkg.sv
rtl/rsm_cell.sv
rtl/rsm_map.sv
rtl/raid_sector_mapper.sv
tb/raid_sector_mapper_tb.sv
